// ----- hdl/least_utilized_node_selector_top_macros.svh -----
// Assertion helpers shared by the checker.
`ifndef LEAST_UTILIZED_NODE_SELECTOR_TOP_MACROS_SVH
`define LEAST_UTILIZED_NODE_SELECTOR_TOP_MACROS_SVH

// A property checked at every rising edge outside of reset.
`define LNS_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A property checked at every rising edge, reset included.
`define LNS_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/lns_pkg.sv -----
`timescale 1ns / 1ps
package lns_pkg;

  localparam int MAX_NODES = 32;
  localparam int MAX_CPUS  = 8;
  localparam int NODE_AW   = $clog2(MAX_NODES);
  localparam int CPU_AW    = $clog2(MAX_CPUS);
  localparam int ENT_AW    = NODE_AW + CPU_AW;
  localparam int ENT_DEPTH = MAX_NODES * MAX_CPUS;
  localparam int NS_W      = 64;
  localparam int US_SHIFT  = 10;
  localparam int US_W      = NS_W - US_SHIFT;
  localparam int SUM_W     = US_W + CPU_AW;
  localparam int HALF_W    = (SUM_W + 1) / 2;
  localparam int PART_W    = 2 * HALF_W;
  localparam int PROD_W    = 2 * SUM_W;
  localparam int ADDR_W    = 32;
  localparam int AGE_W     = 32;
  localparam int CNT_W     = 4;
  localparam int IDX_W     = 3;

  localparam logic [1:0] CMD_UPDATE = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_ADDED     = 3'd1;
  localparam logic [2:0] STAT_FULL      = 3'd2;
  localparam logic [2:0] STAT_CPU_RANGE = 3'd3;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [ADDR_W-1:0] node_addr;
    logic [IDX_W-1:0]  cpu_index;
    logic [CNT_W-1:0]  cpu_count;
    logic [NS_W-1:0]   busy_ns;
    logic [NS_W-1:0]   period_ns;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ADDR_W-1:0] chosen_addr;
    logic              chosen_valid;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  cpus;
    logic [AGE_W-1:0]  age;
  } node_ent_t;

  typedef struct packed {
    logic [US_W-1:0] busy;
    logic [US_W-1:0] period;
  } cpu_ent_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] a;
    logic [SUM_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SRD, S_SCMP, S_SEND, S_UNEW, S_UCLR, S_UWR,
    S_QRD, S_QLAT, S_QSUM, S_QMLS, S_QMLW, S_QMRS, S_QMRW, S_QCMP, S_DONE
  } state_t;

endpackage

// ----- hdl/lns_ram.sv -----
`timescale 1ns / 1ps
module lns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/lns_mul.sv -----
`timescale 1ns / 1ps
module lns_mul
  import lns_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  // Four half-width partial products, one per cycle, each registered
  // before it is added into the accumulator.
  logic [SUM_W-1:0]  a_r, b_r;
  logic [2:0]        step;
  logic              busy, pv, done;
  logic [PART_W-1:0] part;
  logic [1:0]        sh;
  logic [PROD_W-1:0] acc, part_shifted;
  logic [HALF_W-1:0] a_sel, b_sel;

  always_comb begin
    a_sel = step[1] ? HALF_W'(a_r >> HALF_W) : a_r[HALF_W-1:0];
    b_sel = step[0] ? HALF_W'(b_r >> HALF_W) : b_r[HALF_W-1:0];
    case (sh)
      2'd0:    part_shifted = PROD_W'(part);
      2'd1:    part_shifted = PROD_W'(part) << HALF_W;
      default: part_shifted = PROD_W'(part) << (2 * HALF_W);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pv   <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        a_r  <= req.a;
        b_r  <= req.b;
        acc  <= '0;
        step <= '0;
        busy <= 1'b1;
        pv   <= 1'b0;
      end else if (busy) begin
        pv <= (step != 3'd4);
        if (step != 3'd4) begin
          part <= PART_W'(a_sel) * PART_W'(b_sel);
          sh   <= 2'(step[1]) + 2'(step[0]);
        end
        if (pv) begin
          acc <= acc + part_shifted;
        end
        if (step == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 3'd1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.prod = acc;

endmodule

// ----- hdl/least_utilized_node_selector_top.sv -----
`timescale 1ns / 1ps
// Least utilized node selector. Each transfer on req carries one command and
// yields exactly one transfer on rsp. An update finds its node by address, or
// adds it when the address is new, and stores the busy and period times of one
// cpu in units of 1024 ns. A remove deletes a node. A query sums busy and
// period over the cpus of every node and returns the address of the node with
// the smallest busy/period ratio, compared exactly by cross-multiplication;
// equal ratios go to the newest node, and a node at full load or with no
// period is never chosen. The node records sit in one single-port-read memory
// and the per-cpu samples in another, so commands work one at a time. An
// update or remove scans the table, a read and a compare state for each used
// slot and a read state for each free one, then adds a node if needed and
// stores the sample. A query skips free slots and for each used slot makes
// eight sample reads and two 114-bit products built from 29-by-29-bit
// partial products on one shared multiplier. A finished result waits in the
// output register while the next command is taken in.
module least_utilized_node_selector_top
  import lns_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  state_t state, state_next;

  logic [MAX_NODES-1:0] used;
  logic [AGE_W-1:0]     ins_cnt;
  logic [NODE_AW-1:0]   slot, n_r, free_r;
  logic [CPU_AW-1:0]    cnt;
  logic                 found, free_found;
  logic [1:0]           cmd_r;
  logic [ADDR_W-1:0]    addr_r;
  logic [IDX_W-1:0]     cidx_r;
  logic [CNT_W-1:0]     ccnt_r, cpus_r;
  logic [US_W-1:0]      busy_r, per_r;
  logic [2:0]           status_r;
  logic [AGE_W-1:0]     age_r;
  logic [ADDR_W-1:0]    naddr_r;
  logic [SUM_W-1:0]     bs, ps, best_busy, best_per;
  logic [AGE_W-1:0]     best_dist;
  logic [ADDR_W-1:0]    best_addr;
  logic                 best_found;
  logic [PROD_W-1:0]    l_r;

  logic                 slot_last, cnt_last, addr_hit, take, out_free;
  logic [CNT_W-1:0]     ccnt_clamp;
  logic [AGE_W-1:0]     age_gap;

  logic                 node_we, cpu_we;
  logic [NODE_AW-1:0]   node_waddr, node_raddr;
  logic [ENT_AW-1:0]    cpu_waddr, cpu_raddr;
  node_ent_t            node_wdata, node_rd;
  cpu_ent_t             cpu_wdata, cpu_rd;
  mul_req_t             mreq;
  mul_rsp_t             mrsp;

  lns_ram #(.WIDTH($bits(node_ent_t)), .DEPTH(MAX_NODES)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rd)
  );

  lns_ram #(.WIDTH($bits(cpu_ent_t)), .DEPTH(ENT_DEPTH)) u_cpu_ram (
    .clk   (clk),
    .we    (cpu_we),
    .waddr (cpu_waddr),
    .wdata (cpu_wdata),
    .raddr (cpu_raddr),
    .rdata (cpu_rd)
  );

  lns_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  assign slot_last  = (slot == NODE_AW'(MAX_NODES - 1));
  assign cnt_last   = (cnt == CPU_AW'(MAX_CPUS - 1));
  assign addr_hit   = (node_rd.addr == addr_r);
  assign ccnt_clamp = (ccnt_r > CNT_W'(MAX_CPUS)) ? CNT_W'(MAX_CPUS) : ccnt_r;
  assign out_free   = !rsp_valid || rsp_ready;
  assign req_ready  = (state == S_IDLE);

  // Ratio test: bs/ps against the best so far, both sides cross-multiplied.
  assign age_gap = ins_cnt - age_r;
  assign take = (l_r < mrsp.prod) ||
                ((l_r == mrsp.prod) && best_found && (ps != '0) && (age_gap < best_dist));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (req.cmd == CMD_QUERY) begin
            state_next = S_QRD;
          end else if (req.cmd == CMD_UPDATE || req.cmd == CMD_REMOVE) begin
            state_next = S_SRD;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SRD: begin
        if (used[slot]) begin
          state_next = S_SCMP;
        end else if (slot_last) begin
          state_next = S_SEND;
        end
      end
      S_SCMP: begin
        if (addr_hit || slot_last) begin
          state_next = S_SEND;
        end else begin
          state_next = S_SRD;
        end
      end
      S_SEND: begin
        if (cmd_r == CMD_REMOVE) begin
          state_next = S_DONE;
        end else if (found) begin
          state_next = S_UWR;
        end else if (free_found) begin
          state_next = S_UNEW;
        end else begin
          state_next = S_DONE;
        end
      end
      S_UNEW: state_next = S_UCLR;
      S_UCLR: begin
        if (cnt_last) begin
          state_next = S_UWR;
        end
      end
      S_UWR: state_next = S_DONE;
      S_QRD: begin
        if (used[slot]) begin
          state_next = S_QLAT;
        end else if (slot_last) begin
          state_next = S_DONE;
        end
      end
      S_QLAT: state_next = S_QSUM;
      S_QSUM: begin
        if (cnt_last) begin
          state_next = S_QMLS;
        end
      end
      S_QMLS: state_next = S_QMLW;
      S_QMLW: begin
        if (mrsp.done) begin
          state_next = S_QMRS;
        end
      end
      S_QMRS: state_next = S_QMRW;
      S_QMRW: begin
        if (mrsp.done) begin
          state_next = S_QCMP;
        end
      end
      S_QCMP: state_next = slot_last ? S_DONE : S_QRD;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory and multiplier controls.
  always_comb begin
    node_we    = 1'b0;
    node_waddr = free_r;
    node_wdata = '{addr: addr_r, cpus: ccnt_clamp, age: ins_cnt};
    node_raddr = slot;
    cpu_we     = 1'b0;
    cpu_waddr  = {n_r, cnt};
    cpu_wdata  = '0;
    cpu_raddr  = {slot, cnt + CPU_AW'(1)};
    mreq       = '{start: 1'b0, a: bs, b: best_per};
    unique case (state)
      S_UNEW: node_we = 1'b1;
      S_UCLR: cpu_we = 1'b1;
      S_UWR: begin
        cpu_waddr = {n_r, cidx_r[CPU_AW-1:0]};
        cpu_wdata = '{busy: busy_r, period: per_r};
        cpu_we    = (CNT_W'(cidx_r) < cpus_r);
      end
      S_QLAT: cpu_raddr = {slot, CPU_AW'(0)};
      S_QMLS: mreq.start = 1'b1;
      S_QMRS: mreq = '{start: 1'b1, a: best_busy, b: ps};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      ins_cnt   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          cmd_r      <= req.cmd;
          addr_r     <= req.node_addr;
          cidx_r     <= req.cpu_index;
          ccnt_r     <= req.cpu_count;
          busy_r     <= req.busy_ns[NS_W-1:US_SHIFT];
          per_r      <= req.period_ns[NS_W-1:US_SHIFT];
          status_r   <= STAT_OK;
          slot       <= '0;
          found      <= 1'b0;
          free_found <= 1'b0;
          best_busy  <= SUM_W'(1);
          best_per   <= SUM_W'(1);
          best_dist  <= '0;
          best_addr  <= '0;
          best_found <= 1'b0;
        end
        S_SRD: begin
          if (!used[slot]) begin
            if (!free_found) begin
              free_found <= 1'b1;
              free_r     <= slot;
            end
            if (!slot_last) begin
              slot <= slot + NODE_AW'(1);
            end
          end
        end
        S_SCMP: begin
          if (addr_hit) begin
            found  <= 1'b1;
            n_r    <= slot;
            cpus_r <= node_rd.cpus;
          end else if (!slot_last) begin
            slot <= slot + NODE_AW'(1);
          end
        end
        S_SEND: begin
          if (cmd_r == CMD_REMOVE) begin
            if (found) begin
              used[n_r] <= 1'b0;
            end else begin
              status_r <= STAT_NOT_FOUND;
            end
          end else if (!found && !free_found) begin
            status_r <= STAT_FULL;
          end
        end
        S_UNEW: begin
          used[free_r] <= 1'b1;
          ins_cnt      <= ins_cnt + AGE_W'(1);
          n_r          <= free_r;
          cpus_r       <= ccnt_clamp;
          status_r     <= STAT_ADDED;
          cnt          <= '0;
        end
        S_UCLR: cnt <= cnt + CPU_AW'(1);
        S_UWR: begin
          if (CNT_W'(cidx_r) >= cpus_r) begin
            status_r <= STAT_CPU_RANGE;
          end
        end
        S_QRD: begin
          if (!used[slot] && !slot_last) begin
            slot <= slot + NODE_AW'(1);
          end
        end
        S_QLAT: begin
          cpus_r  <= node_rd.cpus;
          age_r   <= node_rd.age;
          naddr_r <= node_rd.addr;
          cnt     <= '0;
          bs      <= '0;
          ps      <= '0;
        end
        S_QSUM: begin
          if (CNT_W'(cnt) < cpus_r) begin
            bs <= bs + SUM_W'(cpu_rd.busy);
            ps <= ps + SUM_W'(cpu_rd.period);
          end
          cnt <= cnt + CPU_AW'(1);
        end
        S_QMLW: begin
          if (mrsp.done) begin
            l_r <= mrsp.prod;
          end
        end
        S_QCMP: begin
          if (take) begin
            best_busy  <= bs;
            best_per   <= ps;
            best_dist  <= age_gap;
            best_addr  <= naddr_r;
            best_found <= 1'b1;
          end
          if (!slot_last) begin
            slot <= slot + NODE_AW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Result register; loaded only when the previous result has been taken.
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      rsp.status       <= status_r;
      rsp.chosen_addr  <= (cmd_r == CMD_QUERY) ? best_addr : '0;
      rsp.chosen_valid <= (cmd_r == CMD_QUERY) && best_found;
    end
  end

endmodule

// ----- hdl/lns_checker.sv -----
`timescale 1ns / 1ps
`include "least_utilized_node_selector_top_macros.svh"
module lns_checker
  import lns_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  // Commands taken in but whose result has not yet been transferred out.
  logic [1:0] pend;
  logic       in_x, out_x;

  assign in_x  = req_valid && req_ready;
  assign out_x = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (in_x && !out_x) begin
      pend <= pend + 2'd1;
    end else if (out_x && !in_x) begin
      pend <= pend - 2'd1;
    end
  end

  `LNS_CHECK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "result dropped while stalled")
  `LNS_CHECK(a_rsp_has_cmd, rsp_valid |-> pend != 2'd0, "result without a pending command")
  `LNS_CHECK(a_pend_bound, pend != 2'd3, "more than two commands in flight")
  `LNS_CHECK(a_chosen_ok, rsp_valid && rsp.chosen_valid |-> rsp.status == STAT_OK, "chosen node with error status")
  `LNS_CHECK_ALWAYS(a_reset_idle, $past(rst) |-> !rsp_valid, "result present after reset")

endmodule

bind least_utilized_node_selector_top lns_checker u_lns_checker (.*);
